[rtl/core/box_blur_3x3_edge_aware_top_macros.svh]
// Assertion macros used by the block's top-level RTL file.
`ifndef BOX_BLUR_3X3_EDGE_AWARE_TOP_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_AWARE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BB3_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define BB3_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BB3_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define BB3_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/bb3_pkg.sv]
package bb3_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int DIM_RESET      = 1024;

   localparam int CH_W      = 8;
   localparam int CHANNELS  = 3;
   localparam int PIX_W     = CHANNELS * CH_W;
   localparam int CFG_W     = 11;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   localparam int TAPS      = 9;
   localparam int TAP_W     = 4;
   localparam int SUM_W     = 12;
   localparam int CNT_W     = 4;
   localparam int NUM_W     = SUM_W + 1;
   localparam int DEN_W     = CNT_W + 1;
   localparam int REM_W     = DEN_W + 1;
   localparam int DIV_CNT_W = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_CHECK,
      ST_READ,
      ST_PREP,
      ST_DIVIDE,
      ST_LOAD
   } state_type;

   typedef enum logic [1:0] {
      OFS_MINUS,
      OFS_ZERO,
      OFS_PLUS
   } ofs_type;

   typedef struct packed {
      logic capture;
      logic store;
      logic setup;
      logic tap_step;
      logic div_load;
      logic div_step;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic drain;
      logic in_frame;
      logic emit;
      logic tap_last;
      logic div_last;
      logic out_free;
   } status_type;

   function automatic ofs_type tap_row(input logic [TAP_W-1:0] tap);
      ofs_type r;
      if (tap < TAP_W'(3)) begin
         r = OFS_MINUS;
      end else if (tap < TAP_W'(6)) begin
         r = OFS_ZERO;
      end else begin
         r = OFS_PLUS;
      end
      return r;
   endfunction

   function automatic ofs_type tap_col(input logic [TAP_W-1:0] tap);
      ofs_type r;
      case (tap)
         TAP_W'(0), TAP_W'(3), TAP_W'(6): r = OFS_MINUS;
         TAP_W'(1), TAP_W'(4), TAP_W'(7): r = OFS_ZERO;
         default: r = OFS_PLUS;
      endcase
      return r;
   endfunction

endpackage

[rtl/core/bb3_ram.sv]
module bb3_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2052
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/bb3_ctrl.sv]
module bb3_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  bb3_pkg::status_type status,
   output bb3_pkg::cmd_type    cmd
);

   import bb3_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = ~reset;
            if (req_tvalid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.in_frame) begin
               if (status.drain) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.store = 1'b1;
                  state_in  = ST_CHECK;
               end
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.emit) begin
               cmd.setup = 1'b1;
               state_in  = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            cmd.tap_step = 1'b1;
            if (status.tap_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.div_load = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/bb3_dp.sv]
module bb3_dp #(
   parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bb3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bb3_pkg::CFG_W-1:0]     csr_wdata,
   input  logic [bb3_pkg::PIX_W-1:0]     req_tdata,
   input  logic                          req_tuser,
   input  bb3_pkg::cmd_type              cmd,
   output bb3_pkg::status_type           status,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bb3_pkg::PIX_W-1:0]     rsp_tdata,
   output logic                          rsp_tlast
);

   import bb3_pkg::*;

   localparam int WW       = $clog2(MAX_WIDTH + 1);
   localparam int HW       = $clog2(MAX_HEIGHT + 1);
   localparam int PW       = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int HIST_LEN = 2 * MAX_WIDTH + 4;
   localparam int AW       = $clog2(HIST_LEN);
   localparam int W_RESET  = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
   localparam int H_RESET  = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

   localparam logic [AW-1:0] LAST_ADDR = AW'(HIST_LEN - 1);
   localparam logic [AW:0]   HIST_X    = (AW + 1)'(HIST_LEN);

   logic [WW-1:0] w_ff, w_in, clamp_w;
   logic [HW-1:0] h_ff, h_in, clamp_h;
   logic [WW+HW-1:0] total_prod;
   logic [PW-1:0] total_ff;

   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] ocount_ff, ocount_in;
   logic [WW-1:0] ocol_ff, ocol_in;
   logic [HW-1:0] orow_ff, orow_in;
   logic [AW-1:0] wp_ff, wp_in;
   logic [AW-1:0] ob_ff, ob_in;
   logic [AW-1:0] up_ff, up_in;
   logic [AW-1:0] dn_ff, dn_in;

   logic             drain_ff, drain_in;
   logic [PIX_W-1:0] pix_ff, pix_in;

   logic [TAP_W-1:0] tap_ff, tap_in;
   logic             okd_ff, okd_in;
   logic [SUM_W-1:0] sum_ff [CHANNELS];
   logic [SUM_W-1:0] sum_in [CHANNELS];
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [NUM_W-1:0]     num_ff [CHANNELS];
   logic [NUM_W-1:0]     num_in [CHANNELS];
   logic [REM_W-1:0]     rem_ff [CHANNELS];
   logic [REM_W-1:0]     rem_in [CHANNELS];
   logic [REM_W-1:0]     shift_rem [CHANNELS];
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] divc_ff, divc_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0] rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   logic [AW:0]      ob_x, w_x, up_x, dn_x, dn_sum;
   logic [PW:0]      emit_thr;
   logic             frame_last;
   logic             col_wrap;
   logic             tap_ok;
   logic             top_edge, bottom_edge, left_edge, right_edge;
   logic             taps_left;
   ofs_type          row_ofs, col_ofs;
   logic [AW-1:0]    row_base, rd_addr;
   logic [PIX_W-1:0] rd_data;
   logic             rd_en;

   bb3_ram #(
      .WIDTH(PIX_W),
      .DEPTH(HIST_LEN)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (cmd.store),
      .wr_addr(wp_ff),
      .wr_data(pix_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      if (csr_wdata == '0) begin
         clamp_w = WW'(1);
      end else if (32'(csr_wdata) > MAX_WIDTH) begin
         clamp_w = WW'(MAX_WIDTH);
      end else begin
         clamp_w = WW'(csr_wdata);
      end
      if (csr_wdata == '0) begin
         clamp_h = HW'(1);
      end else if (32'(csr_wdata) > MAX_HEIGHT) begin
         clamp_h = HW'(MAX_HEIGHT);
      end else begin
         clamp_h = HW'(csr_wdata);
      end
   end

   assign total_prod = w_ff * h_ff;

   assign ob_x   = {1'b0, ob_ff};
   assign w_x    = (AW + 1)'(w_ff);
   assign up_x   = (ob_x >= w_x) ? (ob_x - w_x) : (ob_x + HIST_X - w_x);
   assign dn_sum = ob_x + w_x;
   assign dn_x   = (dn_sum >= HIST_X) ? (dn_sum - HIST_X) : dn_sum;

   assign emit_thr   = (PW + 1)'(ocount_ff) + (PW + 1)'(w_ff) + (PW + 1)'(2);
   assign frame_last = ((PW + 1)'(ocount_ff) + (PW + 1)'(1)) == (PW + 1)'(total_ff);
   assign col_wrap   = ((WW + 1)'(ocol_ff) + (WW + 1)'(1)) == (WW + 1)'(w_ff);

   assign top_edge    = (orow_ff == '0);
   assign bottom_edge = ((HW + 1)'(orow_ff) + (HW + 1)'(1)) >= (HW + 1)'(h_ff);
   assign left_edge   = (ocol_ff == '0);
   assign right_edge  = col_wrap;

   assign row_ofs   = tap_row(tap_ff);
   assign col_ofs   = tap_col(tap_ff);
   assign taps_left = (tap_ff != TAP_W'(TAPS));
   assign rd_en     = cmd.tap_step && taps_left;

   always_comb begin
      unique case (row_ofs)
         OFS_MINUS: row_base = up_ff;
         OFS_ZERO:  row_base = ob_ff;
         OFS_PLUS:  row_base = dn_ff;
         default:   row_base = ob_ff;
      endcase
      unique case (col_ofs)
         OFS_MINUS: rd_addr = (row_base == '0) ? LAST_ADDR : row_base - 1'b1;
         OFS_ZERO:  rd_addr = row_base;
         OFS_PLUS:  rd_addr = (row_base == LAST_ADDR) ? '0 : row_base + 1'b1;
         default:   rd_addr = row_base;
      endcase
      tap_ok = !((row_ofs == OFS_MINUS && top_edge) || (row_ofs == OFS_PLUS && bottom_edge) ||
                 (col_ofs == OFS_MINUS && left_edge) || (col_ofs == OFS_PLUS && right_edge));
   end

   always_comb begin
      status.drain    = drain_ff;
      status.in_frame = (pos_ff < total_ff);
      status.emit     = (ocount_ff < total_ff) &&
                        !((pos_ff != total_ff) && ((PW + 1)'(pos_ff) < emit_thr));
      status.tap_last = !taps_left;
      status.div_last = (divc_ff == DIV_CNT_W'(NUM_W - 1));
      status.out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      w_in         = w_ff;
      h_in         = h_ff;
      pos_in       = pos_ff;
      ocount_in    = ocount_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      wp_in        = wp_ff;
      ob_in        = ob_ff;
      up_in        = up_ff;
      dn_in        = dn_ff;
      drain_in     = drain_ff;
      pix_in       = pix_ff;
      tap_in       = tap_ff;
      okd_in       = okd_ff;
      cnt_in       = cnt_ff;
      den_in       = den_ff;
      divc_in      = divc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      for (int c = 0; c < CHANNELS; c++) begin
         sum_in[c]    = sum_ff[c];
         num_in[c]    = num_ff[c];
         rem_in[c]    = rem_ff[c];
         shift_rem[c] = {rem_ff[c][REM_W-2:0], num_ff[c][NUM_W-1]};
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.capture) begin
         drain_in = req_tuser;
         pix_in   = req_tdata;
      end

      if (cmd.store) begin
         pos_in = pos_ff + 1'b1;
         wp_in  = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
      end

      if (cmd.setup) begin
         up_in  = up_x[AW-1:0];
         dn_in  = dn_x[AW-1:0];
         tap_in = '0;
         okd_in = 1'b0;
         cnt_in = '0;
         for (int c = 0; c < CHANNELS; c++) begin
            sum_in[c] = '0;
         end
      end

      if (cmd.tap_step) begin
         if (taps_left) begin
            tap_in = tap_ff + 1'b1;
         end
         okd_in = taps_left && tap_ok;
         if (okd_ff) begin
            cnt_in = cnt_ff + 1'b1;
            for (int c = 0; c < CHANNELS; c++) begin
               sum_in[c] = sum_ff[c] + SUM_W'(rd_data[c*CH_W +: CH_W]);
            end
         end
      end

      if (cmd.div_load) begin
         den_in  = {cnt_ff, 1'b0};
         divc_in = '0;
         for (int c = 0; c < CHANNELS; c++) begin
            num_in[c] = {sum_ff[c], 1'b0} + NUM_W'(cnt_ff);
            rem_in[c] = '0;
         end
      end

      if (cmd.div_step) begin
         divc_in = divc_ff + 1'b1;
         for (int c = 0; c < CHANNELS; c++) begin
            if (shift_rem[c] >= REM_W'(den_ff)) begin
               rem_in[c] = shift_rem[c] - REM_W'(den_ff);
               num_in[c] = {num_ff[c][NUM_W-2:0], 1'b1};
            end else begin
               rem_in[c] = shift_rem[c];
               num_in[c] = {num_ff[c][NUM_W-2:0], 1'b0};
            end
         end
      end

      if (cmd.load) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = frame_last;
         for (int c = 0; c < CHANNELS; c++) begin
            rsp_data_in[c*CH_W +: CH_W] = num_ff[c][CH_W-1:0];
         end
         if (frame_last) begin
            pos_in    = '0;
            wp_in     = '0;
            ocount_in = '0;
            ocol_in   = '0;
            orow_in   = '0;
            ob_in     = '0;
         end else begin
            ocount_in = ocount_ff + 1'b1;
            ob_in     = (ob_ff == LAST_ADDR) ? '0 : ob_ff + 1'b1;
            if (col_wrap) begin
               ocol_in = '0;
               orow_in = orow_ff + 1'b1;
            end else begin
               ocol_in = ocol_ff + 1'b1;
            end
         end
      end

      if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  w_in = clamp_w;
            REG_FRAME_HEIGHT: h_in = clamp_h;
         endcase
         pos_in    = '0;
         wp_in     = '0;
         ocount_in = '0;
         ocol_in   = '0;
         orow_in   = '0;
         ob_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff         <= WW'(W_RESET);
         h_ff         <= HW'(H_RESET);
         pos_ff       <= '0;
         ocount_ff    <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         wp_ff        <= '0;
         ob_ff        <= '0;
         tap_ff       <= '0;
         okd_ff       <= 1'b0;
         divc_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_ff         <= w_in;
         h_ff         <= h_in;
         pos_ff       <= pos_in;
         ocount_ff    <= ocount_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         wp_ff        <= wp_in;
         ob_ff        <= ob_in;
         tap_ff       <= tap_in;
         okd_ff       <= okd_in;
         divc_ff      <= divc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff    <= total_prod[PW-1:0];
      up_ff       <= up_in;
      dn_ff       <= dn_in;
      drain_ff    <= drain_in;
      pix_ff      <= pix_in;
      cnt_ff      <= cnt_in;
      den_ff      <= den_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      for (int c = 0; c < CHANNELS; c++) begin
         sum_ff[c] <= sum_in[c];
         num_ff[c] <= num_in[c];
         rem_ff[c] <= rem_in[c];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/core/box_blur_3x3_edge_aware_top.sv]
// An item that releases a result passes through these steps before it shows on rsp: the
// pixel is stored, release is checked, the nine neighbors are read from the single read
// port of the line store, the bit-serial divider is loaded and run, and the result is
// loaded into the output register, which waits while rsp still holds an unaccepted result.
// The next transfer is taken in the cycle after that load, or once the item is evaluated or
// checked if it releases no result. Reset is synchronous and active high; it restores 1024 x 1024.
`include "box_blur_3x3_edge_aware_top_macros.svh"

module box_blur_3x3_edge_aware_top #(
   parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [bb3_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bb3_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // in_red, in_green, in_blue
   input  logic [bb3_pkg::PIX_W-1:0]     req_tdata,
   // func
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_red, out_green, out_blue
   output logic [bb3_pkg::PIX_W-1:0]     rsp_tdata,
   output logic                          rsp_tlast
);

   import bb3_pkg::*;

   cmd_type    cmd;
   status_type status;

   bb3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   bb3_dp #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   `BB3_ASSERT_NEXT(a_busy, clock, reset, req_tvalid && req_tready, !req_tready, "input when busy")
   `BB3_ASSERT_IMP(a_load_into_free, clock, reset, cmd.load, status.out_free, "lost result")
   `BB3_ASSERT_IMP(a_store_in_frame, clock, reset, cmd.store, status.in_frame, "late store")
   `BB3_ASSERT_IMP(a_single_cmd, clock, reset, 1'b1, $onehot0(cmd), "two commands")

endmodule
